@@ rtl/mau_pkg.sv @@
// package for the modular arithmetic unit: widths, command codes, divider request and response structs
// no dependencies
`default_nettype none
package mau_pkg;
    localparam int MOD_BITS = 31;
    localparam int OP_BITS  = 64;
    localparam int CMD_BITS = 3;
    localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(1000000007);

    localparam logic [CMD_BITS-1:0] CMD_REDUCE = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_SUB    = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_MUL    = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_DIV    = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_NEG    = 3'd5;

    // request to the shared restoring divider
    typedef struct packed {
        logic                  start;
        logic [OP_BITS-1:0]    dividend;
        logic [MOD_BITS-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [OP_BITS-1:0]    quotient;
        logic [MOD_BITS-1:0]   remainder;
    } div_rsp_t;
endpackage
`default_nettype wire

@@ rtl/mau_divider.sv @@
// shared restoring divider, one quotient bit per cycle, 64-bit dividend
// depends on mau_pkg
`default_nettype none
module mau_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mau_pkg::div_req_t req,
    output mau_pkg::div_rsp_t      rsp
);
    localparam int CNT_BITS = $clog2(mau_pkg::OP_BITS + 1);

    logic                          busy_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic [mau_pkg::OP_BITS-1:0]   quo_reg;
    logic [mau_pkg::MOD_BITS:0]    rem_reg;
    logic [mau_pkg::MOD_BITS-1:0]  dvs_reg;
    logic                          done_reg;
    logic [mau_pkg::MOD_BITS+1:0]  trial;
    logic [mau_pkg::MOD_BITS+1:0]  diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[mau_pkg::OP_BITS-1]};
        diff  = trial - {2'b00, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(mau_pkg::OP_BITS);
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (!diff[mau_pkg::MOD_BITS+1])
                    rem_reg <= diff[mau_pkg::MOD_BITS:0];
                else
                    rem_reg <= trial[mau_pkg::MOD_BITS:0];
                quo_reg <= {quo_reg[mau_pkg::OP_BITS-2:0], ~diff[mau_pkg::MOD_BITS+1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[mau_pkg::MOD_BITS-1:0];
endmodule
`default_nettype wire

@@ rtl/modular_arithmetic_unit.sv @@
// top level of the modular arithmetic unit: sequencer, registers, shared divider
// depends on mau_pkg and mau_divider
`default_nettype none
// one word is taken when start is high and busy is low; busy then stays high
// until the result word is shown on result_value/operands_equal for one cycle
// with done high. the receiver cannot stall, so the word must be captured in
// that cycle. every reduction (operand a, operand b, each product, each euclid
// quotient) runs through one shared restoring divider, so an item costs 2
// divisions for most commands, 3 for multiply, and for divide 3 plus one per
// euclid step (up to about 45 steps for a 31-bit modulus). the modulus register
// is written through cfg_valid/cfg_ready while the unit is idle and no word is
// being offered, and is used as 1 when written as 0.
module modular_arithmetic_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [mau_pkg::CMD_BITS-1:0] command,
    input  wire logic signed [63:0]           operand_a,
    input  wire logic signed [63:0]           operand_b,
    output logic                              done,
    output logic [mau_pkg::MOD_BITS-1:0]      result_value,
    output logic                              operands_equal,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [30:0]                  cfg_data
);
    localparam int MB = mau_pkg::MOD_BITS;
    localparam int OB = mau_pkg::OP_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_RA, S_RB, S_OP, S_MUL, S_EQ, S_EMUL, S_FIX, S_DONE
    } state_t;

    state_t                   state_reg;
    logic [MB-1:0]            mod_reg;
    logic [MB-1:0]            meff;
    logic [mau_pkg::CMD_BITS-1:0] cmd_reg;
    logic [OB-1:0]            opb_reg;
    logic                     nega_reg, negb_reg;
    logic [MB-1:0]            a_reg, b_reg, res_reg;
    logic                     eq_reg, done_reg;
    // euclid: eb / ea remainders, ex / eu signed coefficients
    logic [MB-1:0]            eb_reg, ea_reg;
    logic signed [MB+1:0]     ex_reg, eu_reg;
    logic [MB-1:0]            q_reg;
    mau_pkg::div_req_t        req;
    mau_pkg::div_rsp_t        rsp;
    logic [MB-1:0]            rem;
    logic [MB-1:0]            redrem;
    logic [MB-1:0]            sumr;
    logic [MB:0]              sum;
    logic signed [2*MB+3:0]   qu;
    logic signed [MB+1:0]     xm;
    logic [MB-1:0]            mul_rhs;
    logic [2*MB-1:0]          prod;

    assign meff = (mod_reg == '0) ? MB'(1) : mod_reg;
    assign rem  = rsp.remainder;

    mau_divider u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always_comb
    begin
        sum  = {1'b0, a_reg} + {1'b0, b_reg};
        sumr = (sum >= {1'b0, meff}) ? MB'(sum - {1'b0, meff}) : sum[MB-1:0];
        qu   = $signed({1'b0, q_reg}) * eu_reg;
        xm   = (ex_reg < 0) ? ex_reg + $signed({2'b00, meff}) : ex_reg;
        // one 31 x 31 multiplier: a times b, or a times the inverse
        mul_rhs = (state_reg == S_FIX) ? xm[MB-1:0] : b_reg;
        prod    = a_reg * mul_rhs;
        redrem = rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= mau_pkg::MOD_RESET;
        else if (cfg_valid && cfg_ready)
            mod_reg <= cfg_data[MB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            req.start <= 1'b0;
        end
        else
        begin
            done_reg  <= 1'b0;
            req.start <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        cmd_reg      <= command;
                        opb_reg      <= operand_b;
                        nega_reg     <= operand_a[63];
                        negb_reg     <= operand_b[63];
                        req.start    <= 1'b1;
                        req.dividend <= operand_a[63] ? -operand_a : operand_a;
                        req.divisor  <= meff;
                        state_reg    <= S_RA;
                    end
                S_RA:
                    if (rsp.done)
                    begin
                        a_reg <= (nega_reg && rem != '0) ? meff - rem : rem;
                        req.start    <= 1'b1;
                        req.dividend <= negb_reg ? -opb_reg : opb_reg;
                        state_reg    <= S_RB;
                    end
                S_RB:
                    if (rsp.done)
                    begin
                        b_reg <= (negb_reg && rem != '0) ? meff - rem : rem;
                        state_reg <= S_OP;
                    end
                S_OP:
                begin
                    eq_reg <= (a_reg == b_reg);
                    case (cmd_reg)
                        mau_pkg::CMD_ADD:
                        begin
                            res_reg   <= sumr;
                            state_reg <= S_DONE;
                        end
                        mau_pkg::CMD_SUB:
                        begin
                            res_reg   <= (a_reg >= b_reg) ? a_reg - b_reg
                                                          : a_reg + meff - b_reg;
                            state_reg <= S_DONE;
                        end
                        mau_pkg::CMD_MUL:
                        begin
                            req.start    <= 1'b1;
                            req.dividend <= OB'(prod);
                            state_reg    <= S_MUL;
                        end
                        mau_pkg::CMD_DIV:
                        begin
                            eb_reg <= meff;
                            ea_reg <= b_reg;
                            ex_reg <= '0;
                            eu_reg <= (MB+2)'(1);
                            state_reg <= S_EQ;
                            if (b_reg != '0)
                            begin
                                req.start    <= 1'b1;
                                req.dividend <= OB'(meff);
                                req.divisor  <= b_reg;
                            end
                            else
                                state_reg <= S_FIX;
                        end
                        mau_pkg::CMD_NEG:
                        begin
                            res_reg   <= (a_reg != '0) ? meff - a_reg : '0;
                            state_reg <= S_DONE;
                        end
                        default:
                        begin
                            res_reg   <= a_reg;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_MUL:
                    if (rsp.done)
                    begin
                        res_reg   <= redrem;
                        state_reg <= S_DONE;
                    end
                S_EQ:
                    // quotient of eb / ea ready: rotate remainders
                    if (rsp.done)
                    begin
                        q_reg  <= rsp.quotient[MB-1:0];
                        eb_reg <= ea_reg;
                        ea_reg <= rem;
                        state_reg <= S_EMUL;
                    end
                S_EMUL:
                begin
                    ex_reg <= eu_reg;
                    eu_reg <= ex_reg - (MB+2)'(qu);
                    if (ea_reg != '0)
                    begin
                        req.start    <= 1'b1;
                        req.dividend <= OB'(eb_reg);
                        req.divisor  <= ea_reg;
                        state_reg    <= S_EQ;
                    end
                    else
                        state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    // coefficient stays within plus or minus the modulus
                    req.start    <= 1'b1;
                    req.dividend <= OB'(prod);
                    req.divisor  <= meff;
                    state_reg    <= S_MUL;
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    // no modulus change at the edge that takes a word
    assign cfg_ready      = (state_reg == S_IDLE) && !start;
    assign done           = done_reg;
    assign result_value   = res_reg;
    assign operands_equal = eq_reg;
endmodule
`default_nettype wire

@@ tb/modular_arithmetic_unit_tb.sv @@
// self-checking testbench for modular_arithmetic_unit: directed table, divides mod 12, then random
// words over several moduli, each result checked against a written-out value or a local predictor
// depends on mau_pkg and the modular_arithmetic_unit rtl
`default_nettype none
module modular_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // command codes the unit does not define, which fall back to reduce a
    localparam logic [mau_pkg::CMD_BITS-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [mau_pkg::CMD_BITS-1:0] CMD_SPARE7 = 3'd7;
    localparam longint unsigned     CYCLE_LIMIT = 64'd20_000_000;
    localparam longint unsigned     P_RESET = 64'd1000000007;

    typedef struct {
        logic [mau_pkg::MOD_BITS-1:0] value;
        logic                         equal;
    } result_word_t;

    typedef struct {
        logic [mau_pkg::CMD_BITS-1:0] cmd;
        logic [63:0]                  a;
        logic [63:0]                  b;
        bit                           typed;     // expectation written out below
        logic [mau_pkg::MOD_BITS-1:0] value;
        logic                         equal;
    } vector_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [mau_pkg::CMD_BITS-1:0] command;
    logic signed [63:0]           operand_a;
    logic signed [63:0]           operand_b;
    logic                         done;
    logic [mau_pkg::MOD_BITS-1:0] result_value;
    logic                         operands_equal;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [30:0]                  cfg_data;

    result_word_t    expected_words[$];
    longint unsigned modulus_now;     // effective modulus, 0 already mapped to 1
    int              mismatches;
    longint unsigned cycles;
    bit              no_gaps;

    modular_arithmetic_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .done           (done),
        .result_value   (result_value),
        .operands_equal (operands_equal),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // signed 64-bit operand folded into 0..m-1, negatives wrapped upward
    function automatic longint unsigned residue_of(logic [63:0] raw, longint unsigned m);
        longint unsigned mag;
        longint unsigned r;
        if (raw[63])
        begin
            mag = ~raw + 64'd1;
            r = mag % m;
            return (r != 0) ? m - r : 64'd0;
        end
        return raw % m;
    endfunction

    // extended euclid coefficient of n, whatever it is when n has no inverse
    function automatic longint unsigned inverse_mod(longint unsigned n, longint unsigned m);
        longint x;
        longint u;
        longint rb;
        longint ra;
        longint q;
        longint t;
        x = 0;
        u = 1;
        rb = longint'(m);
        ra = longint'(n);
        while (ra != 0)
        begin
            q = rb / ra;
            t = x - q * u;
            x = u;
            u = t;
            t = rb - q * ra;
            rb = ra;
            ra = t;
        end
        x = x % longint'(m);
        if (x < 0)
            x = x + longint'(m);
        return longint'(x);
    endfunction

    function automatic result_word_t predict_word(logic [mau_pkg::CMD_BITS-1:0] cmd,
                                                  logic [63:0] a_raw, logic [63:0] b_raw);
        longint unsigned m;
        longint unsigned ra;
        longint unsigned rb;
        longint unsigned r;
        result_word_t    w;
        m = modulus_now;
        ra = residue_of(a_raw, m);
        rb = residue_of(b_raw, m);
        case (cmd)
            mau_pkg::CMD_ADD:
            begin
                r = ra + rb;
                if (r >= m)
                    r = r - m;
            end
            mau_pkg::CMD_SUB: r = (ra >= rb) ? ra - rb : ra + m - rb;
            mau_pkg::CMD_MUL: r = (ra * rb) % m;
            mau_pkg::CMD_DIV: r = (ra * inverse_mod(rb, m)) % m;
            mau_pkg::CMD_NEG: r = (ra != 0) ? m - ra : 64'd0;
            default: r = ra;
        endcase
        w.value = r[mau_pkg::MOD_BITS-1:0];
        w.equal = (ra == rb);
        return w;
    endfunction

    // result checker: results are sampled at the edge that ends their cycle
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word value=%0d equal=%0b", $time,
                         result_value, operands_equal);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (result_value !== want.value)
                begin
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             want.value, result_value);
                    mismatches++;
                end
                if (operands_equal !== want.equal)
                begin
                    $display("%0t: operands_equal expected %0b actual %0b", $time,
                             want.equal, operands_equal);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("modular_arithmetic_unit_tb: done, errors");
            $finish;
        end
    end

    // offer one word and hold it until taken, then maybe leave a gap
    task automatic send_word(logic [mau_pkg::CMD_BITS-1:0] cmd, logic [63:0] a,
                             logic [63:0] b, bit typed, result_word_t typed_word);
        int gap;
        int pick;
        start     <= 1'b1;
        command   <= cmd;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (busy);
        // taken at this edge, against the modulus in force now
        expected_words.push_back(typed ? typed_word : predict_word(cmd, a, b));
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let every outstanding word come back and the unit fall idle
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0 || busy);
    endtask

    task automatic write_modulus(logic [30:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        modulus_now = (value == 0) ? 64'd1 : longint'(value);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] random_operand(longint unsigned m);
        int          pick;
        logic [63:0] v;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: v = {$urandom(), $urandom()};
            3:       v = 64'($urandom_range(0, 20));
            4:       v = -longint'($urandom_range(1, 20));
            5:       v = m * $urandom_range(0, 3);
            6:       v = -longint'(m * $urandom_range(1, 3));
            7:       v = m - 1;
            8:       v = {1'b1, 63'd0} | 64'($urandom_range(0, 3));
            default: v = $urandom() % (m + 1);
        endcase
        return v;
    endfunction

    task automatic random_phase(int count);
        logic [63:0]  a;
        logic [63:0]  b;
        result_word_t none;
        none = '{default: '0};
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
        begin
            a = random_operand(modulus_now);
            // equal operands now and then, to exercise the equality flag
            if ($urandom_range(0, 5) == 0)
                b = a;
            else
                b = random_operand(modulus_now);
            send_word(3'($urandom_range(0, 7)), a, b, 1'b0, none);
        end
    endtask

    vector_t vectors[] = '{
        '{mau_pkg::CMD_REDUCE, 64'd0, 64'd0, 1, 31'd0, 1'b1},
        '{mau_pkg::CMD_REDUCE, -64'sd1, 64'd0, 1, 31'd1000000006, 1'b0},
        '{mau_pkg::CMD_REDUCE, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 0, '0, 0},
        '{mau_pkg::CMD_REDUCE, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 0, '0, 0},
        '{mau_pkg::CMD_ADD, 64'd1000000006, 64'd1, 1, 31'd0, 1'b0},
        '{mau_pkg::CMD_ADD, 64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 0, '0, 0},
        '{mau_pkg::CMD_SUB, 64'd0, 64'd1, 1, 31'd1000000006, 1'b0},
        '{mau_pkg::CMD_SUB, 64'd1000000007, 64'd0, 1, 31'd0, 1'b1},
        '{mau_pkg::CMD_MUL, -64'sd1, -64'sd1, 1, 31'd1, 1'b1},
        '{mau_pkg::CMD_MUL, 64'd1000000006, 64'd1000000005, 0, '0, 0},
        '{mau_pkg::CMD_DIV, 64'd5, 64'd0, 1, 31'd0, 1'b0},
        '{mau_pkg::CMD_DIV, 64'd1, 64'd2, 1, 31'd500000004, 1'b0},
        '{mau_pkg::CMD_DIV, 64'h8000_0000_0000_0000, 64'd1000000006, 0, '0, 0},
        '{mau_pkg::CMD_NEG, 64'd1, 64'd1, 1, 31'd1000000006, 1'b1},
        '{mau_pkg::CMD_NEG, 64'd0, 64'd3, 1, 31'd0, 1'b0},
        '{CMD_SPARE6, 64'd5, 64'd5, 1, 31'd5, 1'b1},
        '{CMD_SPARE7, -64'sd7, 64'd0, 1, 31'd1000000000, 1'b0}
    };

    initial
    begin
        longint unsigned moduli[];
        result_word_t    typed_word;
        result_word_t    none;
        moduli = '{64'd12, 64'd1, 64'd0, 64'd2147483647, 64'd2, 64'd1000000007, 64'd97};
        none = '{default: '0};
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = '0;
        operand_a   = '0;
        operand_b   = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        mismatches  = 0;
        cycles      = 0;
        no_gaps     = 1'b0;
        modulus_now = P_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset modulus
        foreach (vectors[i])
        begin
            typed_word.value = vectors[i].value;
            typed_word.equal = vectors[i].equal;
            send_word(vectors[i].cmd, vectors[i].a, vectors[i].b, vectors[i].typed, typed_word);
        end

        // composite modulus: divisors without an inverse
        write_modulus(31'd12);
        send_word(mau_pkg::CMD_DIV, 64'd3, 64'd4, 1'b0, none);
        send_word(mau_pkg::CMD_DIV, 64'd5, 64'd6, 1'b0, none);
        send_word(mau_pkg::CMD_DIV, -64'sd1, 64'd9, 1'b0, none);

        // random part, one phase per modulus, extremes first
        foreach (moduli[i])
        begin
            write_modulus(moduli[i][30:0]);
            random_phase(110);
        end
        for (int i = 0; i < 6; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                write_modulus(31'($urandom_range(1, 200)));
            else
                write_modulus(31'($urandom()));
            random_phase(100);
        end

        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("modular_arithmetic_unit_tb: done, clean");
        else
            $display("modular_arithmetic_unit_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
